### rtl/core/gs5_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gs5_pkg
// Shared types and constants of the five-tap Gaussian RGBA smoother.
// ----------------------------------------------------------------------------
package gs5_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int NUM_CHANNELS = 4;
  localparam int COEF_BITS    = 16;
  localparam int ACC_BITS     = CHANNEL_BITS + COEF_BITS;
  localparam int CFG_INDEX_BITS = 4;

  localparam logic [COEF_BITS-1:0] TAP_OUTER  = COEF_BITS'(677);
  localparam logic [COEF_BITS-1:0] TAP_INNER  = COEF_BITS'(13602);
  localparam logic [COEF_BITS-1:0] TAP_CENTER = COEF_BITS'(36975);

  localparam logic [CFG_INDEX_BITS-1:0] REG_RED_ENABLE   = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_GREEN_ENABLE = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLUE_ENABLE  = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA_ENABLE = CFG_INDEX_BITS'(3);

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_ALPHA = 3;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] chan_word_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
    logic  last;
  } pixel_in_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
    logic  last;
  } pixel_out_t;

endpackage

### rtl/core/gaussian5_smoother_rgba.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian5_smoother_rgba
// Streaming five-tap Gaussian smoother for RGBA table runs, edges replicated.
//
//   channel  | signals                              | flow
//   ---------+--------------------------------------+---------
//   in       | in_valid, in_stall, in_data          | to block
//   out      | out_valid, out_stall, out_data       | from block
//   cfg      | cfg_valid, cfg_ready, cfg_index/data | to block
//
// One entry is taken per cycle unless input is stalled; results lag by
// two entries of the run. The entry marked last is pushed twice more as
// a flush, stalling input. Results pass through a two-entry buffer, so
// input stalls only when the buffer is full or a flush is running.
// Synchronous reset clears the run state and sets all channel enables.
// ----------------------------------------------------------------------------
module gaussian5_smoother_rgba (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  gs5_pkg::pixel_in_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output gs5_pkg::pixel_out_t                    out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [gs5_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic                                   cfg_data
);

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;

  localparam logic [1:0] FLUSH_IDLE  = 2'd0;
  localparam logic [1:0] FLUSH_FINAL = 2'd1;
  localparam logic [1:0] FLUSH_START = 2'd2;

  gs5_pkg::chan_word_t                 hist0, hist1, hist2, hist3;
  gs5_pkg::chan_word_t                 flush_entry;
  gs5_pkg::chan_word_t                 entry_in;
  gs5_pkg::chan_word_t                 src;
  gs5_pkg::chan_word_t                 filt;
  logic [1:0]                          seen;
  logic [1:0]                          flush_left;
  logic [gs5_pkg::NUM_CHANNELS-1:0]    enable;
  logic                                flushing;
  logic                                fifo_full;
  logic                                in_fire;
  logic                                push;
  logic                                res_valid;
  gs5_pkg::pixel_out_t                 res;

  assign entry_in[gs5_pkg::CH_RED]   = in_data.red;
  assign entry_in[gs5_pkg::CH_GREEN] = in_data.green;
  assign entry_in[gs5_pkg::CH_BLUE]  = in_data.blue;
  assign entry_in[gs5_pkg::CH_ALPHA] = in_data.alpha;

  assign flushing  = (flush_left != FLUSH_IDLE);
  assign in_stall  = flushing || fifo_full;
  assign in_fire   = in_valid && !in_stall;
  assign push      = flushing ? !fifo_full : in_fire;
  assign src       = flushing ? flush_entry : entry_in;
  assign res_valid = push && (seen == SEEN_TWO);
  assign cfg_ready = 1'b1;

  gs5_filter u_filter (
    .tap0   (hist3),
    .tap1   (hist2),
    .tap2   (hist1),
    .tap3   (hist0),
    .tap4   (src),
    .enable (enable),
    .result (filt)
  );

  always_comb begin
    res.red   = filt[gs5_pkg::CH_RED];
    res.green = filt[gs5_pkg::CH_GREEN];
    res.blue  = filt[gs5_pkg::CH_BLUE];
    res.alpha = filt[gs5_pkg::CH_ALPHA];
    res.last  = (flush_left == FLUSH_FINAL);
  end

  gs5_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (fifo_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // advance the delay line and capture the last entry for the flush
  always_ff @(posedge clk) begin
    if (push) begin
      if (seen == SEEN_NONE) begin
        hist0 <= src;
        hist1 <= src;
        hist2 <= src;
        hist3 <= src;
      end else begin
        hist0 <= src;
        hist1 <= hist0;
        hist2 <= hist1;
        hist3 <= hist2;
      end
    end
    if (in_fire && in_data.last) begin
      flush_entry <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen       <= SEEN_NONE;
      flush_left <= FLUSH_IDLE;
      enable     <= '1;
    end else begin
      if (push) begin
        if (flushing && (flush_left == FLUSH_FINAL)) begin
          seen <= SEEN_NONE;
        end else if (seen == SEEN_NONE) begin
          seen <= SEEN_ONE;
        end else begin
          seen <= SEEN_TWO;
        end
      end
      if (flushing && !fifo_full) begin
        flush_left <= flush_left - 2'd1;
      end else if (in_fire && in_data.last) begin
        flush_left <= FLUSH_START;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          gs5_pkg::REG_RED_ENABLE:   enable[gs5_pkg::CH_RED]   <= cfg_data;
          gs5_pkg::REG_GREEN_ENABLE: enable[gs5_pkg::CH_GREEN] <= cfg_data;
          gs5_pkg::REG_BLUE_ENABLE:  enable[gs5_pkg::CH_BLUE]  <= cfg_data;
          gs5_pkg::REG_ALPHA_ENABLE: enable[gs5_pkg::CH_ALPHA] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

### rtl/core/gs5_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gs5_filter
// Symmetric five-tap Q0.16 Gaussian over four channels, with per-channel
// bypass. Sum is truncated to the channel width.
// ----------------------------------------------------------------------------
module gs5_filter (
  input  gs5_pkg::chan_word_t                     tap0,
  input  gs5_pkg::chan_word_t                     tap1,
  input  gs5_pkg::chan_word_t                     tap2,
  input  gs5_pkg::chan_word_t                     tap3,
  input  gs5_pkg::chan_word_t                     tap4,
  input  logic [gs5_pkg::NUM_CHANNELS-1:0]        enable,
  output gs5_pkg::chan_word_t                     result
);

  localparam int SUM_BITS = gs5_pkg::CHANNEL_BITS + 1;
  localparam int ACC_BITS = gs5_pkg::ACC_BITS;

  logic [gs5_pkg::NUM_CHANNELS-1:0][SUM_BITS-1:0] outer_sum;
  logic [gs5_pkg::NUM_CHANNELS-1:0][SUM_BITS-1:0] inner_sum;
  logic [gs5_pkg::NUM_CHANNELS-1:0][ACC_BITS-1:0] acc;

  always_comb begin
    for (int c = 0; c < gs5_pkg::NUM_CHANNELS; c++) begin
      outer_sum[c] = SUM_BITS'(tap0[c]) + SUM_BITS'(tap4[c]);
      inner_sum[c] = SUM_BITS'(tap1[c]) + SUM_BITS'(tap3[c]);
      acc[c] = ACC_BITS'(outer_sum[c]) * ACC_BITS'(gs5_pkg::TAP_OUTER)
             + ACC_BITS'(inner_sum[c]) * ACC_BITS'(gs5_pkg::TAP_INNER)
             + ACC_BITS'(tap2[c]) * ACC_BITS'(gs5_pkg::TAP_CENTER);
      if (enable[c]) begin
        result[c] = acc[c][ACC_BITS-1 -: gs5_pkg::CHANNEL_BITS];
      end else begin
        result[c] = tap2[c];
      end
    end
  end

endmodule

### rtl/core/gs5_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gs5_out_fifo
// Two-entry result buffer; full flag is registered so the input side never
// sees the output stall combinationally.
// ----------------------------------------------------------------------------
module gs5_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  gs5_pkg::pixel_out_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output gs5_pkg::pixel_out_t out_data
);

  gs5_pkg::pixel_out_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (!push && pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

endmodule
